FILE: rtl/bba_pkg.sv
// Package for the buddy block allocator: sizes, field widths, table entry format,
// status and operation codes, controller states and size helper functions.
// Depends on nothing; every module of the allocator imports it.
package bba_pkg;

   localparam int TOTAL_UNITS = 1024;
   localparam int MIN_BLOCK   = 64;
   localparam int NUM_SLOTS   = (TOTAL_UNITS / MIN_BLOCK) > 0 ? (TOTAL_UNITS / MIN_BLOCK) : 1;
   localparam int SLOT_W      = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
   localparam int MIN_SHIFT   = $clog2(MIN_BLOCK);
   localparam int LEVELS      = $clog2(NUM_SLOTS);
   localparam int TOP_CODE    = LEVELS + 1;
   localparam int CODE_W      = $clog2(TOP_CODE + 1);

   localparam int REQ_W    = 11;
   localparam int IDX_W    = 10;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // A code of zero marks an entry that is not a block head; otherwise the
   // block holds MIN_BLOCK << (code - 1) units.
   typedef struct packed {
      logic              used;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } table_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_RD,
      ST_A_EVAL,
      ST_A_SPLIT,
      ST_F_RD,
      ST_F_CHK,
      ST_F_BRD,
      ST_F_BCHK,
      ST_F_MERGE,
      ST_DONE
   } state_type;

   function automatic logic [SIZE_W-1:0] code_to_size(input logic [CODE_W-1:0] code);
      logic [SIZE_W-1:0] size;
      size = '0;
      if (code != '0) begin
         size = SIZE_W'(MIN_BLOCK) << (code - CODE_W'(1));
      end
      return size;
   endfunction

   function automatic logic [SLOT_W:0] code_to_slots(input logic [CODE_W-1:0] code);
      logic [SLOT_W:0] slots;
      slots = (SLOT_W+1)'(1);
      if (code != '0) begin
         slots = (SLOT_W+1)'(1) << (code - CODE_W'(1));
      end
      return slots;
   endfunction

endpackage

FILE: rtl/bba_table.sv
// Block table of the buddy allocator: one entry per minimum block in a synchronous
// memory with a read and a write port, registered read data and per-entry valid bits.
// Depends on bba_pkg.
module bba_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [bba_pkg::SLOT_W-1:0] rd_addr,
   output bba_pkg::entry_type   rd_data,
   input  bba_pkg::table_wr_type wr
);
   import bba_pkg::*;

   entry_type             mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  valid_ff;
   entry_type             rd_data_ff;
   entry_type             reset_entry;

   // An entry never written reads as its reset value: the whole memory free at slot zero.
   always_comb begin
      reset_entry = '0;
      if (rd_addr == '0) begin
         reset_entry.code = CODE_W'(TOP_CODE);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff[rd_addr]) begin
         rd_data_ff <= mem[rd_addr];
      end else begin
         rd_data_ff <= reset_entry;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: request decode, table controller and
// result register. Depends on bba_pkg and bba_table.
//
// The allocator manages 1024 units in power-of-two blocks of at least 64 units,
// keeping one table entry per 64-unit slot in a 16-entry memory with registered
// read data. One request is handled at a time. An allocate is accepted, reads and
// evaluates each block head on its scan from unit 0, writes both halves of each
// block it halves and reads the lower half again, and hands the result over. A
// free is accepted, reads and checks the block, then reads and checks the buddy
// at each merge level (up to four) and writes the merged block, stops at a buddy
// that does not merge, and hands over the result; an index that is out of range
// or not aligned goes straight to the hand-over. The result sits in an output
// register, so the next request is accepted once the previous one has finished its
// table updates and moved its result there, even while that waits for rsp_ready.
module buddy_block_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [bba_pkg::REQ_W-1:0]     req_request_size,
   input  logic [bba_pkg::IDX_W-1:0]     req_block_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bba_pkg::IDX_W-1:0]     rsp_block_start,
   output logic [bba_pkg::SIZE_W-1:0]    rsp_granted_size
);
   import bba_pkg::*;

   state_type          state_ff, state_in;
   logic [SLOT_W:0]    i_ff;
   logic [SLOT_W-1:0]  cur_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [REQ_W-1:0]   req_size_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [IDX_W-1:0]   res_index_ff;
   logic [SIZE_W-1:0]  res_size_ff;
   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [SIZE_W-1:0]  rsp_size_ff;

   logic [SLOT_W-1:0]  rd_addr;
   entry_type          rd_data;
   table_wr_type       wr;

   logic               accept;
   logic               free_bad;
   logic [SLOT_W-1:0]  free_slot;
   logic [SIZE_W-1:0]  ent_size;
   logic               ent_head;
   logic               do_split;
   logic               do_fit;
   logic [SLOT_W:0]    i_next;
   logic               scan_end;
   logic [SLOT_W-1:0]  half_slots;
   logic [SLOT_W-1:0]  buddy_slot;
   logic               buddy_ok;
   logic               out_free;

   bba_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign free_bad = (32'(req_block_index) >= TOTAL_UNITS) ||
                     ((32'(req_block_index) % MIN_BLOCK) != 0);
   assign free_slot = SLOT_W'(32'(req_block_index) >> MIN_SHIFT);

   always_comb begin
      ent_size   = code_to_size(rd_data.code);
      ent_head   = rd_data.code != '0;
      do_split   = ent_head && !rd_data.used && (rd_data.code > CODE_W'(1)) &&
                   ({1'b0, ent_size} >= {req_size_ff, 1'b0});
      do_fit     = ent_head && !rd_data.used && (ent_size >= req_size_ff);
      i_next     = i_ff + code_to_slots(rd_data.code);
      scan_end   = 32'(i_next) >= NUM_SLOTS;
      half_slots = SLOT_W'(code_to_slots(code_ff));
      buddy_slot = cur_ff ^ half_slots;
      buddy_ok   = !rd_data.used && (rd_data.code == code_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == OP_ALLOC) begin
                  state_in = ST_A_RD;
               end else if (free_bad) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_F_RD;
               end
            end
         end
         ST_A_RD:   state_in = ST_A_EVAL;
         ST_A_EVAL: begin
            if (do_split) begin
               state_in = ST_A_SPLIT;
            end else if (do_fit || scan_end) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_A_RD;
            end
         end
         ST_A_SPLIT: state_in = ST_A_RD;
         ST_F_RD:    state_in = ST_F_CHK;
         ST_F_CHK: begin
            if (!ent_head || !rd_data.used || rd_data.code == CODE_W'(TOP_CODE)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_F_BRD;
            end
         end
         ST_F_BRD:  state_in = ST_F_BCHK;
         ST_F_BCHK: state_in = buddy_ok ? ST_F_MERGE : ST_DONE;
         ST_F_MERGE: begin
            if (code_ff + CODE_W'(1) == CODE_W'(TOP_CODE)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_F_BRD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Table accesses and handshake outputs.
   always_comb begin
      rd_addr   = '0;
      wr        = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_A_RD: rd_addr = i_ff[SLOT_W-1:0];
         ST_A_EVAL: begin
            if (do_split) begin
               wr.en        = 1'b1;
               wr.addr      = i_ff[SLOT_W-1:0];
               wr.data.used = 1'b0;
               wr.data.code = rd_data.code - CODE_W'(1);
            end else if (do_fit) begin
               wr.en        = 1'b1;
               wr.addr      = i_ff[SLOT_W-1:0];
               wr.data.used = 1'b1;
               wr.data.code = rd_data.code;
            end
         end
         ST_A_SPLIT: begin
            wr.en        = 1'b1;
            wr.addr      = i_ff[SLOT_W-1:0] ^ half_slots;
            wr.data.used = 1'b0;
            wr.data.code = code_ff;
         end
         ST_F_RD: rd_addr = cur_ff;
         ST_F_CHK: begin
            if (ent_head && rd_data.used) begin
               wr.en        = 1'b1;
               wr.addr      = cur_ff;
               wr.data.used = 1'b0;
               wr.data.code = rd_data.code;
            end
         end
         ST_F_BRD: rd_addr = buddy_slot;
         ST_F_BCHK: begin
            if (buddy_ok) begin
               wr.en   = 1'b1;
               wr.addr = cur_ff | half_slots;
               wr.data = '0;
            end
         end
         ST_F_MERGE: begin
            wr.en        = 1'b1;
            wr.addr      = cur_ff;
            wr.data.used = 1'b0;
            wr.data.code = code_ff + CODE_W'(1);
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               i_ff          <= '0;
               cur_ff        <= free_slot;
               req_size_ff   <= req_request_size;
               res_status_ff <= STATUS_BAD_FREE;
               res_index_ff  <= '0;
               res_size_ff   <= '0;
            end
         end
         ST_A_EVAL: begin
            if (do_split) begin
               code_ff <= rd_data.code - CODE_W'(1);
            end else if (do_fit) begin
               res_status_ff <= STATUS_DONE;
               res_index_ff  <= IDX_W'(32'(i_ff) << MIN_SHIFT);
               res_size_ff   <= ent_size;
            end else begin
               i_ff <= i_next;
               if (scan_end) begin
                  res_status_ff <= STATUS_NO_FIT;
                  res_index_ff  <= '0;
                  res_size_ff   <= '0;
               end
            end
         end
         ST_F_CHK: begin
            code_ff <= rd_data.code;
            if (ent_head && rd_data.used) begin
               res_status_ff <= STATUS_DONE;
               res_index_ff  <= IDX_W'(32'(cur_ff) << MIN_SHIFT);
               res_size_ff   <= ent_size;
            end
         end
         ST_F_BCHK: begin
            if (buddy_ok) begin
               cur_ff <= cur_ff & ~half_slots;
            end
         end
         ST_F_MERGE: code_ff <= code_ff + CODE_W'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_start  = rsp_index_ff;
   assign rsp_granted_size = rsp_size_ff;

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DONE) |->
         (rsp_block_start == '0 && rsp_granted_size == '0))
      else $error("error transfer carries a nonzero index or size");

   a_grant_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DONE) |->
         ($onehot(rsp_granted_size) &&
          (({1'b0, rsp_block_start} & (rsp_granted_size - SIZE_W'(1))) == '0)))
      else $error("granted block is not a power of two aligned to its size");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ready || state_ff == ST_DONE) |-> !wr.en)
      else $error("table written while no request is in progress");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid && req_ready))
      else $error("finished request did not reach the output register");

endmodule

FILE: verif/tb_buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// Testbench for buddy_block_allocator_top: a directed pass and a long random pass
// check every result against a block-table predictor kept in a scoreboard class.
// Depends on bba_pkg and the allocator RTL.
module tb_buddy_block_allocator_top;
   import bba_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 1530;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    start;
      logic [SIZE_W-1:0]   units;
   } grant_type;

   class buddy_scoreboard;
      logic [SIZE_W-1:0] blk_size [NUM_SLOTS];
      logic              blk_used [NUM_SLOTS];
      grant_type         pending_grants[$];
      logic [IDX_W-1:0]  live_heads[$];
      int                errors;

      function new();
         foreach (blk_size[s]) begin
            blk_size[s] = '0;
            blk_used[s] = 1'b0;
         end
         blk_size[0] = SIZE_W'(TOTAL_UNITS);
         errors = 0;
      endfunction

      function grant_type carve_block(logic [REQ_W-1:0] want);
         grant_type         g;
         int unsigned       pos;
         int unsigned       s;
         logic [SIZE_W-1:0] sz;
         logic [SIZE_W-1:0] half;
         bit                found;
         g.status = STATUS_NO_FIT;
         g.start  = '0;
         g.units  = '0;
         pos = 0;
         found = 1'b0;
         while (!found && pos < TOTAL_UNITS) begin
            s = pos / MIN_BLOCK;
            sz = blk_size[s];
            if (sz == '0) begin
               pos += MIN_BLOCK;
            end else if (!blk_used[s] && {1'b0, sz} >= {want, 1'b0}
                         && sz > SIZE_W'(MIN_BLOCK)) begin
               half = sz >> 1;
               blk_size[s] = half;
               blk_size[(pos ^ half) / MIN_BLOCK] = half;
               blk_used[(pos ^ half) / MIN_BLOCK] = 1'b0;
            end else if (!blk_used[s] && sz >= want) begin
               blk_used[s] = 1'b1;
               g.status = STATUS_DONE;
               g.start  = IDX_W'(pos);
               g.units  = sz;
               live_heads.push_back(IDX_W'(pos));
               found = 1'b1;
            end else begin
               pos += sz;
            end
         end
         return g;
      endfunction

      function grant_type release_block(logic [IDX_W-1:0] idx);
         grant_type         g;
         int unsigned       cur;
         int unsigned       buddy;
         int unsigned       left;
         int unsigned       b;
         int unsigned       s;
         logic [SIZE_W-1:0] sz;
         bit                merging;
         g.status = STATUS_BAD_FREE;
         g.start  = '0;
         g.units  = '0;
         s = idx / MIN_BLOCK;
         if (idx < TOTAL_UNITS && idx % MIN_BLOCK == 0 && blk_size[s] != '0 && blk_used[s]) begin
            blk_used[s] = 1'b0;
            sz = blk_size[s];
            g.status = STATUS_DONE;
            g.start  = idx;
            g.units  = sz;
            for (int k = 0; k < live_heads.size(); k++) begin
               if (live_heads[k] == idx) begin
                  live_heads.delete(k);
                  break;
               end
            end
            cur = idx;
            merging = 1'b1;
            while (merging && sz < TOTAL_UNITS) begin
               buddy = cur ^ sz;
               merging = 1'b0;
               if (buddy < TOTAL_UNITS) begin
                  b = buddy / MIN_BLOCK;
                  if (!blk_used[b] && blk_size[b] == sz) begin
                     left = (cur < buddy) ? cur : buddy;
                     blk_size[(left ^ sz) / MIN_BLOCK] = '0;
                     blk_used[(left ^ sz) / MIN_BLOCK] = 1'b0;
                     blk_size[left / MIN_BLOCK] = sz << 1;
                     blk_used[left / MIN_BLOCK] = 1'b0;
                     cur = left;
                     sz = sz << 1;
                     merging = 1'b1;
                  end
               end
            end
         end
         return g;
      endfunction

      function void note_request(logic op, logic [REQ_W-1:0] want, logic [IDX_W-1:0] idx);
         if (op == OP_ALLOC) begin
            pending_grants.push_back(carve_block(want));
         end else begin
            pending_grants.push_back(release_block(idx));
         end
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] start,
                                 logic [SIZE_W-1:0] units);
         grant_type g;
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result, status %0d start %0d size %0d",
                     $time, status, start, units);
            errors++;
         end else begin
            g = pending_grants.pop_front();
            if (status !== g.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d", $time, g.status, status);
               errors++;
            end
            if (start !== g.start) begin
               $display("%0t: block start mismatch, expected %0d, got %0d",
                        $time, g.start, start);
               errors++;
            end
            if (units !== g.units) begin
               $display("%0t: granted_size mismatch, expected %0d, got %0d",
                        $time, g.units, units);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [REQ_W-1:0]    req_request_size;
   logic [IDX_W-1:0]    req_block_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_block_start;
   logic [SIZE_W-1:0]   rsp_granted_size;

   buddy_scoreboard sb;
   bit              no_idle;
   bit              hold_req;
   int              idle_cycles;

   buddy_block_allocator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_request_size (req_request_size),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_block_start  (rsp_block_start),
      .rsp_granted_size (rsp_granted_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [REQ_W-1:0] wanted_units();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return REQ_W'($urandom_range(0, 64));
      if (r < 65) return REQ_W'($urandom_range(65, 256));
      if (r < 80) return REQ_W'($urandom_range(257, TOTAL_UNITS));
      if (r < 88) return REQ_W'(MIN_BLOCK << $urandom_range(0, LEVELS));
      if (r < 95) return REQ_W'((1 << $urandom_range(0, 10)) + $urandom_range(0, 2) - 1);
      return REQ_W'($urandom_range(TOTAL_UNITS + 1, (1 << REQ_W) - 1));
   endfunction

   task automatic issue(input logic op, input logic [REQ_W-1:0] want,
                        input logic [IDX_W-1:0] idx);
      int gap;
      req_valid        <= 1'b1;
      req_type         <= op;
      req_request_size <= want;
      req_block_index  <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, want, idx);
      gap = idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_grants();
      req_valid <= 1'b0;
      while (sb.pending_grants.size() != 0) @(posedge clock);
   endtask

   initial begin : rsp_sink
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_status, rsp_block_start, rsp_granted_size);
         end
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 35) stall_left = idle_span();
         end
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("buddy_block_allocator_top verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int r;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = OP_ALLOC;
      req_request_size = '0;
      req_block_index = '0;
      no_idle = 1'b0;
      hold_req = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Whole memory, oversized and zero requests, bad frees and full merges.
      issue(OP_ALLOC, REQ_W'(1024), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(1), IDX_W'($urandom));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(0));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(0));
      issue(OP_ALLOC, REQ_W'(2047), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(1025), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(0), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(64), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(65), IDX_W'($urandom));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(64));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(32));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(1023));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(192));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(0));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(128));
      issue(OP_ALLOC, REQ_W'(512), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(512), IDX_W'($urandom));
      issue(OP_ALLOC, REQ_W'(0), IDX_W'($urandom));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(512));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(0));
      issue(OP_ALLOC, REQ_W'(1), IDX_W'($urandom));
      issue(OP_FREE, REQ_W'($urandom), IDX_W'(0));
      drain_grants();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n == 250) begin
            no_idle = 1'b1;
            hold_req = 1'b1;
         end
         if (n == 700) drain_grants();
         r = $urandom_range(0, 99);
         if (r < 45 || sb.live_heads.size() == 0) begin
            issue(OP_ALLOC, wanted_units(), IDX_W'($urandom));
         end else if (r < 85) begin
            issue(OP_FREE, REQ_W'($urandom),
                  sb.live_heads[$urandom_range(0, sb.live_heads.size() - 1)]);
         end else if (r < 93) begin
            issue(OP_FREE, REQ_W'($urandom),
                  IDX_W'($urandom_range(0, NUM_SLOTS - 1) * MIN_BLOCK));
         end else begin
            issue(OP_FREE, REQ_W'($urandom), IDX_W'($urandom_range(0, TOTAL_UNITS - 1)));
         end
      end

      drain_grants();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
         $display("buddy_block_allocator_top verification clean");
      end else begin
         $display("buddy_block_allocator_top verification failed");
      end
      $finish;
   end

endmodule
